@@ rtl/core/toal_pkg.sv @@
`default_nettype none
package toal_pkg;
  typedef enum logic [2:0] {
    CMD_DATA   = 3'd0,
    CMD_MARKER = 3'd1,
    CMD_STABLE = 3'd2,
    CMD_ABORTQ = 3'd3,
    CMD_EVICT  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_OPEN  = 3'd1,
    ST_OPEN_FUL = 3'd2,
    ST_LOG_FUL  = 3'd3,
    ST_NO_MATCH = 3'd4
  } status_t;

  typedef logic [62:0] offset_t;
  typedef logic [31:0] prod_t;
endpackage
`default_nettype wire

@@ rtl/core/toal_ram.sv @@
`default_nettype none
module toal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/txn_open_table_and_abort_log_core.sv @@
`default_nettype none
// Data, marker and stable commands scan the open table; a marker then scans the abort log.
// Evict and aborted queries scan the abort log; unused codes go straight to the result beat.
// An aborted query emits its matching ranges lowest first offset first, or reports no match.
// Throughput: one item at a time; each pass walks a one-read-port RAM one entry per cycle.
// Output register lets the next item start while a result waits; a stalled output holds S_EMIT or S_OUT.
// Reset (rst, synchronous) clears all valid bits and control; RAM contents are not cleared.
module txn_open_table_and_abort_log_core #(
  parameter int OPEN_DEPTH  = 16,
  parameter int ABORT_DEPTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [2:0]              command,
  input  wire logic [31:0]             producer,
  input  wire logic                    is_abort,
  input  wire logic [62:0]             batch_offset,
  input  wire logic [62:0]             marker_position,
  input  wire logic [62:0]             watermark,
  input  wire logic [62:0]             fetch_start,
  input  wire logic [62:0]             log_begin,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [2:0]                   status,
  output logic [62:0]                  stable_offset,
  output logic [31:0]                  range_producer,
  output logic [62:0]                  range_first,
  output logic                         last_item
);
  import toal_pkg::*;

  localparam int OAW = (OPEN_DEPTH > 1) ? $clog2(OPEN_DEPTH) : 1;
  localparam int AAW = (ABORT_DEPTH > 1) ? $clog2(ABORT_DEPTH) : 1;
  localparam int OCW = $clog2(OPEN_DEPTH + 1);
  localparam int ACW = $clog2(ABORT_DEPTH + 1);
  localparam int RIW = (OCW > ACW) ? OCW : ACW;
  localparam int MAX_RES = 16;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_OSCAN = 7'b0000010,
    S_ASCAN = 7'b0000100,
    S_SORT  = 7'b0001000,
    S_EMIT  = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [2:0]  cmd;
  prod_t       prod;
  logic        abrt;
  offset_t     boff, mpos, wm, fst, lbeg;

  logic [OPEN_DEPTH-1:0]  open_valid;
  logic [ABORT_DEPTH-1:0] abort_valid;
  logic [ABORT_DEPTH-1:0] done;

  logic [OCW-1:0] ocnt;
  logic [ACW-1:0] acnt;
  logic           rd_pend;
  logic [RIW-1:0] rd_idx;

  // RAM ports
  logic           op_we, of_we, ap_we, af_we, am_we;
  logic [OAW-1:0] o_waddr, o_raddr;
  logic [AAW-1:0] a_waddr, a_raddr;
  prod_t          op_rd, ap_rd, ap_wd;
  offset_t        of_rd, af_rd, am_rd, of_wd, af_wd, am_wd;

  toal_ram #(.WIDTH(32), .DEPTH(OPEN_DEPTH)) u_op (
    .clk(clk), .we(op_we), .waddr(o_waddr), .wdata(prod), .raddr(o_raddr), .rdata(op_rd));
  toal_ram #(.WIDTH(63), .DEPTH(OPEN_DEPTH)) u_of (
    .clk(clk), .we(of_we), .waddr(o_waddr), .wdata(of_wd), .raddr(o_raddr), .rdata(of_rd));
  toal_ram #(.WIDTH(32), .DEPTH(ABORT_DEPTH)) u_ap (
    .clk(clk), .we(ap_we), .waddr(a_waddr), .wdata(ap_wd), .raddr(a_raddr), .rdata(ap_rd));
  toal_ram #(.WIDTH(63), .DEPTH(ABORT_DEPTH)) u_af (
    .clk(clk), .we(af_we), .waddr(a_waddr), .wdata(af_wd), .raddr(a_raddr), .rdata(af_rd));
  toal_ram #(.WIDTH(63), .DEPTH(ABORT_DEPTH)) u_am (
    .clk(clk), .we(am_we), .waddr(a_waddr), .wdata(am_wd), .raddr(a_raddr), .rdata(am_rd));

  // scan results
  logic           hit;
  logic [OAW-1:0] hit_slot;
  offset_t        hit_first;
  logic           ofree_ok, afree_ok;
  logic [OAW-1:0] ofree;
  logic [AAW-1:0] afree;
  offset_t        lso;
  logic [4:0]     nemit, total;
  logic           best_ok;
  logic [AAW-1:0] best;
  offset_t        best_first;
  prod_t          best_prod;
  logic           emit_go;

  logic [OAW-1:0] rd_oslot;
  logic [AAW-1:0] rd_aslot;
  assign rd_oslot = rd_idx[OAW-1:0];
  assign rd_aslot = rd_idx[AAW-1:0];

  assign in_ready = (state == S_IDLE);
  // output register loads a new beat when empty or being drained
  assign emit_go  = (state == S_EMIT || state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    o_raddr = ocnt[OAW-1:0];
    a_raddr = acnt[AAW-1:0];
    op_we = 1'b0; of_we = 1'b0; ap_we = 1'b0; af_we = 1'b0; am_we = 1'b0;
    o_waddr = ofree; a_waddr = afree;
    of_wd = boff; ap_wd = prod; af_wd = hit_first; am_wd = mpos;
    if (state == S_WRITE) begin
      if (cmd == CMD_DATA && !hit && ofree_ok) begin
        op_we = 1'b1; of_we = 1'b1;
      end
      if (cmd == CMD_MARKER && hit && abrt && afree_ok) begin
        ap_we = 1'b1; af_we = 1'b1; am_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      open_valid  <= '0;
      abort_valid <= '0;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd <= command; prod <= producer; abrt <= is_abort;
            boff <= batch_offset; mpos <= marker_position; wm <= watermark;
            fst <= fetch_start; lbeg <= log_begin;
            hit <= 1'b0; ofree_ok <= 1'b0; afree_ok <= 1'b0;
            hit_slot <= '0; ofree <= '0; afree <= '0;
            lso <= watermark; nemit <= '0; total <= '0;
            ocnt <= '0; acnt <= '0; rd_pend <= 1'b0;
            if (command == CMD_DATA || command == CMD_MARKER || command == CMD_STABLE) begin
              state <= S_OSCAN;
            end else if (command == CMD_ABORTQ || command == CMD_EVICT) begin
              state <= S_ASCAN;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OSCAN: begin
          if (ocnt != OCW'(OPEN_DEPTH)) ocnt <= ocnt + 1'b1;
          rd_pend <= (ocnt != OCW'(OPEN_DEPTH));
          rd_idx  <= RIW'(ocnt);
          if (rd_pend) begin
            if (!open_valid[rd_oslot] && !ofree_ok) begin
              ofree_ok <= 1'b1; ofree <= rd_oslot;
            end
            if (open_valid[rd_oslot] && op_rd == prod && !hit) begin
              hit <= 1'b1; hit_slot <= rd_oslot; hit_first <= of_rd;
            end
            if (open_valid[rd_oslot] && of_rd < lso) lso <= of_rd;
          end else if (ocnt == OCW'(OPEN_DEPTH)) begin
            acnt <= '0;
            if (cmd == CMD_MARKER) begin
              state <= S_ASCAN;
            end else if (cmd == CMD_DATA) begin
              state <= S_WRITE;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_ASCAN: begin
          // free slot search, match marking, eviction
          if (acnt != ACW'(ABORT_DEPTH)) acnt <= acnt + 1'b1;
          rd_pend <= (acnt != ACW'(ABORT_DEPTH));
          rd_idx  <= RIW'(acnt);
          if (rd_pend) begin
            if (!abort_valid[rd_aslot] && !afree_ok) begin
              afree_ok <= 1'b1; afree <= rd_aslot;
            end
            done[rd_aslot] <= !(abort_valid[rd_aslot] && am_rd > fst);
            if (abort_valid[rd_aslot] && am_rd > fst && total != 5'(MAX_RES))
              total <= total + 1'b1;
            if (cmd == CMD_EVICT && abort_valid[rd_aslot] && am_rd < lbeg)
              abort_valid[rd_aslot] <= 1'b0;
          end else if (acnt == ACW'(ABORT_DEPTH)) begin
            acnt <= '0;
            best_ok <= 1'b0;
            if (cmd == CMD_MARKER) state <= S_WRITE;
            else if (cmd == CMD_ABORTQ && total != '0) state <= S_SORT;
            else state <= S_OUT;
          end
        end
        S_SORT: begin
          if (acnt != ACW'(ABORT_DEPTH)) acnt <= acnt + 1'b1;
          rd_pend <= (acnt != ACW'(ABORT_DEPTH));
          rd_idx  <= RIW'(acnt);
          if (rd_pend) begin
            if (!done[rd_aslot] && (!best_ok || af_rd < best_first)) begin
              best_ok <= 1'b1; best <= rd_aslot; best_first <= af_rd; best_prod <= ap_rd;
            end
          end else if (acnt == ACW'(ABORT_DEPTH)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            status         <= ST_OK;
            stable_offset  <= '0;
            range_producer <= best_prod;
            range_first    <= best_first;
            last_item      <= (nemit + 1'b1 == total);
            done[best]     <= 1'b1;
            nemit          <= nemit + 1'b1;
            acnt           <= '0;
            best_ok        <= 1'b0;
            state          <= (nemit + 1'b1 == total) ? S_IDLE : S_SORT;
          end
        end
        S_WRITE: begin
          if (cmd == CMD_DATA && !hit && ofree_ok) open_valid[ofree] <= 1'b1;
          if (cmd == CMD_MARKER && hit && (!abrt || afree_ok))
            open_valid[hit_slot] <= 1'b0;
          if (cmd == CMD_MARKER && hit && abrt && afree_ok) abort_valid[afree] <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (emit_go) begin
            stable_offset  <= (cmd == CMD_STABLE) ? lso : '0;
            range_producer <= '0;
            range_first    <= '0;
            last_item      <= 1'b1;
            case (cmd)
              CMD_DATA:   status <= (!hit && !ofree_ok) ? ST_OPEN_FUL : ST_OK;
              CMD_MARKER: status <= !hit ? ST_NO_OPEN :
                                    (abrt && !afree_ok) ? ST_LOG_FUL : ST_OK;
              CMD_ABORTQ: status <= ST_NO_MATCH;
              default:    status <= ST_OK;
            endcase
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
